[hw/rtl/srms_pkg.sv]
`default_nettype none

package srms_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned CH_W     = 5;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RMS_W    = 16;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned ROOT_W   = SUM_W / 2;
  localparam int unsigned TDATA_W  = 24;

  // Defaults
  localparam int unsigned NUM_CHANNELS = 18;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd500;

  // Status from the divide / square-root unit to the sequencer
  typedef struct packed {
    logic             done;
    logic [RMS_W-1:0] rms;
  } unit_sts_t;

  // Command from the sequencer to the divide / square-root unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [WIN_W-1:0] divisor;
  } unit_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/srms_divsqrt.sv]
`default_nettype none

module srms_divsqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srms_pkg::unit_cmd_t cmd,
  output srms_pkg::unit_sts_t    sts
);

  localparam int unsigned SUM_W  = srms_pkg::SUM_W;
  localparam int unsigned ROOT_W = srms_pkg::ROOT_W;
  localparam int unsigned WIN_W  = srms_pkg::WIN_W;
  localparam int unsigned RMS_W  = srms_pkg::RMS_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned OP_W   = REM_W + 2;
  localparam int unsigned CNT_W  = $clog2(SUM_W);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_DIV  = 4'b0010,
    U_SQRT = 4'b0100,
    U_DONE = 4'b1000
  } ustate_t;

  ustate_t            state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [WIN_W-1:0]   div_r, div_nxt;

  logic [WIN_W:0]     rem_sh;
  logic [OP_W-1:0]    op_a;
  logic [OP_W-1:0]    op_b;
  logic [OP_W:0]      diff;
  logic               ge;

  // Shared compare-subtract: long-division step or square-root digit step
  assign rem_sh = {rem_r[WIN_W-1:0], dvd_r[SUM_W-1]};

  always_comb begin
    if (state_r == U_SQRT) begin
      op_a = {rem_r, dvd_r[SUM_W-1 -: 2]};
      op_b = {2'b00, root_r, 2'b01};
    end else begin
      op_a = {{(OP_W-WIN_W-1){1'b0}}, rem_sh};
      op_b = {{(OP_W-WIN_W){1'b0}}, div_r};
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[OP_W];

  // Sequence the divide steps, then the root steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    div_nxt   = div_r;
    case (state_r)
      U_IDLE: begin
        if (cmd.start) begin
          dvd_nxt   = cmd.sum;
          div_nxt   = cmd.divisor;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SUM_W - 1);
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        dvd_nxt = {dvd_r[SUM_W-2:0], ge};
        rem_nxt = ge ? {{(REM_W-WIN_W){1'b0}}, diff[WIN_W-1:0]}
                     : {{(REM_W-WIN_W){1'b0}}, rem_sh[WIN_W-1:0]};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          state_nxt = U_SQRT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      U_SQRT: begin
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          // first root step starts from a clear remainder
          root_nxt = {{(ROOT_W-1){1'b0}}, 1'b0};
        end
        dvd_nxt  = {dvd_r[SUM_W-3:0], 2'b00};
        rem_nxt  = ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = U_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      U_DONE: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Clear the remainder and root when the root phase begins
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    if (state_r == U_DIV && cnt_r == '0) begin
      rem_r  <= '0;
      root_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  // Saturate the root to the output width
  assign sts.done = (state_r == U_DONE);
  assign sts.rms  = (root_r[ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}} : root_r[RMS_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/staggered_multichannel_rms.sv]
`default_nettype none

// Staggered multichannel RMS. Feed one channel sample per transaction, frame by
// frame in channel order. Each channel sums its squared samples; a frame counter
// (0 to window_length-1) advances after the last channel, and when it equals a
// channel's index that channel reports floor(sqrt(sum / window_length)) and its
// sum is cleared, so the windows of the channels close in different frames.
// Channel indexes at or above NUM_CHANNELS are dropped without effect. Sums
// saturate at 2^48-1; window_length 0 acts as 1. Steps: an item that reports
// nothing passes accept, square and accumulate; a reporting item then goes to
// one shared subtractor that runs 48 restoring divide steps and then 24
// square-root digit steps; the root, saturated to 2^16-1, is collected and
// loaded into the output register once that register is free.
// A finished result sits in the output register while the next item is taken.
module staggered_multichannel_rms #(
  parameter int unsigned NUM_CHANNELS = srms_pkg::NUM_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // channel [4:0], sample [20:5], zero fill [23:21]
  input  wire logic [srms_pkg::TDATA_W-1:0]  in_tdata,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // channel_res [4:0], rms_value [20:5], zero fill [23:21]
  output      logic [srms_pkg::TDATA_W-1:0]  out_tdata,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_we,
  input  wire logic [srms_pkg::WIN_W-1:0]    cfg_wdata
);

  localparam int unsigned CH_W     = srms_pkg::CH_W;
  localparam int unsigned SAMPLE_W = srms_pkg::SAMPLE_W;
  localparam int unsigned RMS_W    = srms_pkg::RMS_W;
  localparam int unsigned WIN_W    = srms_pkg::WIN_W;
  localparam int unsigned SUM_W    = srms_pkg::SUM_W;
  localparam int unsigned SQ_W     = srms_pkg::SQ_W;
  localparam int unsigned TDATA_W  = srms_pkg::TDATA_W;
  localparam int unsigned IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_SQ   = 5'b00010,
    T_ACC  = 5'b00100,
    T_CALC = 5'b01000,
    T_OUT  = 5'b10000
  } tstate_t;

  tstate_t               state_r, state_nxt;
  logic [WIN_W-1:0]      window_r;
  logic [WIN_W-1:0]      frame_r;
  logic [CH_W-1:0]       ch_r;
  logic [SAMPLE_W-1:0]   mag_r;
  logic [SQ_W-1:0]       sq_r;
  logic [SUM_W-1:0]      sums_r [NUM_CHANNELS];
  logic [RMS_W-1:0]      rms_r;
  logic                  out_valid_r;
  logic [CH_W-1:0]       out_ch_r;
  logic [RMS_W-1:0]      out_rms_r;

  logic [CH_W-1:0]       in_ch;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [SAMPLE_W-1:0]   in_mag;
  logic                  in_fire;
  logic                  ch_ok;
  logic [IDX_W-1:0]      idx;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W-1:0]      sum_new;
  logic [WIN_W-1:0]      win_eff;
  logic                  report;
  logic                  last_ch;
  logic [WIN_W:0]        frame_inc;
  logic                  out_free;
  srms_pkg::unit_cmd_t   ucmd;
  srms_pkg::unit_sts_t   usts;

  // Unpack the input transaction
  assign in_ch     = in_tdata[CH_W-1:0];
  assign in_sample = in_tdata[CH_W +: SAMPLE_W];
  assign in_mag    = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign in_tready = (state_r == T_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign ch_ok     = ({1'b0, in_ch} < (CH_W+1)'(NUM_CHANNELS));

  // Accumulate with saturation
  assign idx     = ch_r[IDX_W-1:0];
  assign sum_add = {1'b0, sums_r[idx]} + {{(SUM_W+1-SQ_W){1'b0}}, sq_r};
  assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  assign win_eff   = (window_r == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : window_r;
  assign report    = (frame_r == {{(WIN_W-CH_W){1'b0}}, ch_r});
  assign last_ch   = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign frame_inc = {1'b0, frame_r} + 1'b1;
  assign out_free  = ~out_valid_r | out_tready;

  assign ucmd.start   = (state_r == T_ACC) & report;
  assign ucmd.sum     = sum_new;
  assign ucmd.divisor = win_eff;

  srms_divsqrt u_divsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ucmd),
    .sts  (usts)
  );

  // Sequence one item
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: if (in_fire && ch_ok) state_nxt = T_SQ;
      T_SQ:   state_nxt = T_ACC;
      T_ACC:  state_nxt = report ? T_CALC : T_IDLE;
      T_CALC: if (usts.done) state_nxt = T_OUT;
      T_OUT:  if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the window length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= srms_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // Capture the sample and square its magnitude
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r  <= in_ch;
      mag_r <= in_mag;
    end
    if (state_r == T_SQ) begin
      sq_r <= {{(SQ_W-SAMPLE_W){1'b0}}, mag_r} * {{(SQ_W-SAMPLE_W){1'b0}}, mag_r};
    end
    if (state_r == T_CALC && usts.done) begin
      rms_r <= usts.rms;
    end
  end

  // Update the channel sum and the frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        sums_r[k] <= '0;
      end
      frame_r <= '0;
    end else if (state_r == T_ACC) begin
      sums_r[idx] <= report ? '0 : sum_new;
      if (last_ch) begin
        frame_r <= (frame_inc >= {1'b0, win_eff}) ? '0 : frame_inc[WIN_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == T_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_OUT && out_free) begin
      out_ch_r  <= ch_r;
      out_rms_r <= rms_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-CH_W-RMS_W){1'b0}}, out_rms_r, out_ch_r};

endmodule

`default_nettype wire
